// ===== sv/mbg_pkg.sv =====
// Shared types, codes and constants of the maze backtracker generator.
// No dependencies; every other file depends on this package.
package mbg_pkg;

  // Default geometry and stack size
  localparam int DEF_ROWS        = 15;
  localparam int DEF_COLS        = 30;
  localparam int DEF_STACK_DEPTH = 128;

  // Field widths of the request and result channels
  localparam int MODE_W  = 2;
  localparam int ORD_W   = 5;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 5;
  localparam int EV_W    = 3;
  localparam int KIND_W  = 2;
  localparam int LVL_W   = 8;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  // Cell kinds
  localparam logic [KIND_W-1:0] KIND_WALL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXIT = 2'd2;

  // Move directions, two cells at a time
  localparam logic [1:0] DIR_PCOL = 2'd0;
  localparam logic [1:0] DIR_NCOL = 2'd1;
  localparam logic [1:0] DIR_PROW = 2'd2;
  localparam logic [1:0] DIR_NROW = 2'd3;

  // Result events
  typedef enum logic [EV_W-1:0] {
    EV_IGNORED     = 3'd0,
    EV_CARVED      = 3'd1,
    EV_BACKTRACKED = 3'd2,
    EV_FINISHED    = 3'd3,
    EV_RESTARTED   = 3'd4,
    EV_CELL_READ   = 3'd5
  } mbg_event_e;

  // Grid memory operations
  typedef enum logic [2:0] {
    GOP_NONE,
    GOP_CLEAR,
    GOP_RD_TARGET,
    GOP_RD_USER,
    GOP_WR_PASS,
    GOP_WR_TARGET,
    GOP_WR_START,
    GOP_WR_EXIT
  } mbg_grid_op_e;

  // Backtrack stack operations
  typedef enum logic [2:0] {
    STK_NONE,
    STK_READ,
    STK_PUSH,
    STK_POP,
    STK_INIT
  } mbg_stk_op_e;

  // Controller to datapath
  typedef struct packed {
    logic         load_item;
    mbg_grid_op_e grid_op;
    mbg_stk_op_e  stk_op;
    logic         try_clear;
    logic         try_next;
    logic         out_load;
    mbg_event_e   out_event;
  } mbg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              sp_zero;
    logic              sp_one;
    logic              clear_done;
    logic              in_bounds;
    logic              target_wall;
    logic              try_last;
  } mbg_status_t;

  // Lexicographic direction orders, first try in the low bits
  localparam logic [7:0] PERM_TABLE [24] = '{
    {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
    {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
    {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
    {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
    {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
    {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
    {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
    {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
    {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
    {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
    {2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
    {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
  };

  // Order index taken modulo 24, then looked up
  function automatic logic [7:0] order_perm(input logic [ORD_W-1:0] idx);
    logic [ORD_W-1:0] red;
    red = (idx >= 5'd24) ? idx - 5'd24 : idx;
    return PERM_TABLE[red];
  endfunction

endpackage

// ===== sv/mbg_if.sv =====
// Request and result channel interfaces of the maze backtracker generator.
// Depends on mbg_pkg for field widths.

interface mbg_item_if;
  logic                      valid;
  logic                      ready;
  logic [mbg_pkg::MODE_W-1:0] mode;
  logic [mbg_pkg::ORD_W-1:0]  order_index;
  logic [mbg_pkg::ROW_W-1:0]  read_row;
  logic [mbg_pkg::COL_W-1:0]  read_col;

  modport source (output valid, output mode, output order_index, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input mode, input order_index, input read_row,
                  input read_col, output ready);
endinterface

interface mbg_result_if;
  logic                       valid;
  logic                       ready;
  logic [mbg_pkg::EV_W-1:0]   event_res;
  logic [mbg_pkg::COL_W-1:0]  cell_col;
  logic [mbg_pkg::ROW_W-1:0]  cell_row;
  logic [mbg_pkg::COL_W-1:0]  passage_col;
  logic [mbg_pkg::ROW_W-1:0]  passage_row;
  logic [mbg_pkg::KIND_W-1:0] cell_kind;
  logic [mbg_pkg::LVL_W-1:0]  stack_level;

  modport source (output valid, output event_res, output cell_col, output cell_row,
                  output passage_col, output passage_row, output cell_kind,
                  output stack_level, input ready);
  modport sink   (input valid, input event_res, input cell_col, input cell_row,
                  input passage_col, input passage_row, input cell_kind,
                  input stack_level, output ready);
endinterface

// ===== sv/maze_backtracker_generator_core.sv =====
// Maze backtracker generator, top level: controller, datapath and assertions.
// Depends on mbg_pkg, mbg_if (mbg_item_if, mbg_result_if), mbg_ctrl, mbg_datapath.
//
// Usage: requests arrive on item_i (valid/ready); each request gives exactly one
// result on result_o (valid/ready). Mode 0 restarts, mode 1 carves one step,
// mode 2 reads one cell; mode 3 and a step on an empty stack report "ignored".
// The block works on one request at a time: ready is high only when idle, and the
// idle state is entered as the result turns valid.
// Each direction tried is first checked against the border; a target inside the
// border is then read from the grid memory and tested for a wall.
// Restart sweeps the grid memory one cell a cycle, then writes the start cell and
// puts it on the stack.
// After reset the same sweep runs with ready low, then the grid is all walls and
// the stack empty.
// Results sit in an output register; a stalled receiver holds the result and the
// next request is still accepted and worked on up to its own result, which then
// waits for the register to empty.
module maze_backtracker_generator_core #(
  parameter int ROWS        = mbg_pkg::DEF_ROWS,
  parameter int COLS        = mbg_pkg::DEF_COLS,
  parameter int STACK_DEPTH = mbg_pkg::DEF_STACK_DEPTH
) (
  input logic          clk_i,
  input logic          rst_ni,
  mbg_item_if.sink     item_i,
  mbg_result_if.source result_o
);
  import mbg_pkg::*;

  mbg_cmd_t    cmd;
  mbg_status_t status;

  // Sequencer
  mbg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Grid, stack and result register
  mbg_datapath #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (item_i.mode),
    .order_index_i (item_i.order_index),
    .read_row_i    (item_i.read_row),
    .read_col_i    (item_i.read_col),
    .cmd_i         (cmd),
    .status_o      (status),
    .event_res_o   (result_o.event_res),
    .cell_col_o    (result_o.cell_col),
    .cell_row_o    (result_o.cell_row),
    .passage_col_o (result_o.passage_col),
    .passage_row_o (result_o.passage_row),
    .cell_kind_o   (result_o.cell_kind),
    .stack_level_o (result_o.stack_level)
  );

  // One request in flight: an accepted request drops ready
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("request accepted while another is in work");

  // A finished maze leaves the stack empty
  a_finish_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.event_res == EV_FINISHED |-> result_o.stack_level == '0)
    else $error("finish reported with cells left on the stack");

  // A restart reports the start cell and a single stacked cell
  a_restart_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.event_res == EV_RESTARTED |->
      result_o.stack_level == LVL_W'(1) && result_o.cell_row == ROW_W'(1) &&
      result_o.cell_col == COL_W'(1))
    else $error("restart result does not match the start cell");

endmodule

// ===== sv/mbg_datapath.sv =====
// Datapath: grid memory, backtrack stack memory, move generation and result register.
// Depends on mbg_pkg; driven by mbg_ctrl through mbg_cmd_t.
module mbg_datapath #(
  parameter int ROWS        = mbg_pkg::DEF_ROWS,
  parameter int COLS        = mbg_pkg::DEF_COLS,
  parameter int STACK_DEPTH = mbg_pkg::DEF_STACK_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mbg_pkg::MODE_W-1:0] mode_i,
  input  logic [mbg_pkg::ORD_W-1:0]  order_index_i,
  input  logic [mbg_pkg::ROW_W-1:0]  read_row_i,
  input  logic [mbg_pkg::COL_W-1:0]  read_col_i,
  input  mbg_pkg::mbg_cmd_t          cmd_i,
  output mbg_pkg::mbg_status_t       status_o,
  output logic [mbg_pkg::EV_W-1:0]   event_res_o,
  output logic [mbg_pkg::COL_W-1:0]  cell_col_o,
  output logic [mbg_pkg::ROW_W-1:0]  cell_row_o,
  output logic [mbg_pkg::COL_W-1:0]  passage_col_o,
  output logic [mbg_pkg::ROW_W-1:0]  passage_row_o,
  output logic [mbg_pkg::KIND_W-1:0] cell_kind_o,
  output logic [mbg_pkg::LVL_W-1:0]  stack_level_o
);
  import mbg_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int EW    = RW + CW;
  localparam logic [AW-1:0] START_ADDR = AW'(COLS + 1);
  localparam logic [AW-1:0] EXIT_ADDR  = AW'((ROWS - 2) * COLS + COLS - 2);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] r,
                                              input logic [AW-1:0] c);
    return r * AW'(COLS) + c;
  endfunction

  // Captured request fields
  logic [MODE_W-1:0] mode_q;
  logic [ORD_W-1:0]  order_q;
  logic [ROW_W-1:0]  rd_row_q;
  logic [COL_W-1:0]  rd_col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q   <= mode_i;
      order_q  <= order_index_i;
      rd_row_q <= read_row_i;
      rd_col_q <= read_col_i;
    end
  end

  // Backtrack stack
  logic [EW-1:0]  stk_mem [STACK_DEPTH];
  logic [EW-1:0]  stk_rdata_q;
  logic [SPW-1:0] sp_q, sp_d, sp_dec;
  logic           stk_room;
  logic [RW-1:0]  top_row, tgt_row, pas_row;
  logic [CW-1:0]  top_col, tgt_col, pas_col;

  assign sp_dec   = sp_q - 1'b1;
  assign stk_room = sp_q < SPW'(STACK_DEPTH);
  assign top_row  = stk_rdata_q[EW-1:CW];
  assign top_col  = stk_rdata_q[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_op == STK_PUSH && stk_room) begin
      stk_mem[sp_q[SAW-1:0]] <= {tgt_row, tgt_col};
    end else if (cmd_i.stk_op == STK_INIT) begin
      stk_mem[SAW'(0)] <= {RW'(1), CW'(1)};
    end
    if (cmd_i.stk_op == STK_READ) begin
      stk_rdata_q <= stk_mem[sp_dec[SAW-1:0]];
    end
  end

  // Stack pointer; a push onto a full stack is dropped
  always_comb begin
    sp_d = sp_q;
    case (cmd_i.stk_op)
      STK_PUSH: if (stk_room) sp_d = sp_q + 1'b1;
      STK_POP:  sp_d = sp_dec;
      STK_INIT: sp_d = SPW'(1);
      default:  sp_d = sp_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  // Direction try counter
  logic [1:0] try_q;
  logic [7:0] perm;
  logic [1:0] dir;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      try_q <= '0;
    end else if (cmd_i.try_clear) begin
      try_q <= '0;
    end else if (cmd_i.try_next) begin
      try_q <= try_q + 2'd1;
    end
  end

  assign perm = order_perm(order_q);
  assign dir  = perm[2*try_q +: 2];

  // Target and passage cell of the current try, with the border check
  logic [CW:0] col_x, tgt_col_x, pas_col_x;
  logic [RW:0] row_x, tgt_row_x, pas_row_x;
  logic        in_bounds;

  assign col_x = {1'b0, top_col};
  assign row_x = {1'b0, top_row};

  always_comb begin
    tgt_col_x = col_x;
    pas_col_x = col_x;
    tgt_row_x = row_x;
    pas_row_x = row_x;
    in_bounds = 1'b0;
    case (dir)
      DIR_PCOL: begin
        tgt_col_x = col_x + (CW+1)'(2);
        pas_col_x = col_x + (CW+1)'(1);
        in_bounds = tgt_col_x < (CW+1)'(COLS - 1);
      end
      DIR_NCOL: begin
        tgt_col_x = col_x - (CW+1)'(2);
        pas_col_x = col_x - (CW+1)'(1);
        in_bounds = col_x > (CW+1)'(2);
      end
      DIR_PROW: begin
        tgt_row_x = row_x + (RW+1)'(2);
        pas_row_x = row_x + (RW+1)'(1);
        in_bounds = tgt_row_x < (RW+1)'(ROWS - 1);
      end
      DIR_NROW: begin
        tgt_row_x = row_x - (RW+1)'(2);
        pas_row_x = row_x - (RW+1)'(1);
        in_bounds = row_x > (RW+1)'(2);
      end
      default: in_bounds = 1'b0;
    endcase
  end

  assign tgt_col = tgt_col_x[CW-1:0];
  assign pas_col = pas_col_x[CW-1:0];
  assign tgt_row = tgt_row_x[RW-1:0];
  assign pas_row = pas_row_x[RW-1:0];

  // Grid memory and clearing sweep
  logic [KIND_W-1:0] grid_mem [CELLS];
  logic [KIND_W-1:0] grid_rdata_q;
  logic [AW-1:0]     clr_q;
  logic [AW-1:0]     waddr, raddr;
  logic [KIND_W-1:0] wdata;
  logic              we, re;
  logic              user_in_range;

  assign user_in_range = (32'(rd_row_q) < 32'(ROWS)) && (32'(rd_col_q) < 32'(COLS));

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = clr_q;
    raddr = cell_addr(AW'(tgt_row), AW'(tgt_col));
    wdata = KIND_WALL;
    case (cmd_i.grid_op)
      GOP_CLEAR:     we = 1'b1;
      GOP_RD_TARGET: re = 1'b1;
      GOP_RD_USER: begin
        re    = user_in_range;
        raddr = cell_addr(AW'(rd_row_q), AW'(rd_col_q));
      end
      GOP_WR_PASS: begin
        we    = 1'b1;
        waddr = cell_addr(AW'(pas_row), AW'(pas_col));
        wdata = KIND_OPEN;
      end
      GOP_WR_TARGET: begin
        we    = 1'b1;
        waddr = cell_addr(AW'(tgt_row), AW'(tgt_col));
        wdata = KIND_OPEN;
      end
      GOP_WR_START: begin
        we    = 1'b1;
        waddr = START_ADDR;
        wdata = KIND_OPEN;
      end
      GOP_WR_EXIT: begin
        we    = 1'b1;
        waddr = EXIT_ADDR;
        wdata = KIND_EXIT;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      grid_mem[waddr] <= wdata;
    end
    if (re) begin
      grid_rdata_q <= grid_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.grid_op == GOP_CLEAR) begin
      clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + 1'b1;
    end
  end

  // Status back to the controller
  assign status_o.mode        = mode_q;
  assign status_o.sp_zero     = sp_q == '0;
  assign status_o.sp_one      = sp_q == SPW'(1);
  assign status_o.clear_done  = clr_q == LAST_ADDR;
  assign status_o.in_bounds   = in_bounds;
  assign status_o.target_wall = grid_rdata_q == KIND_WALL;
  assign status_o.try_last    = try_q == 2'd3;

  // Result fields for the event being reported
  logic [COL_W-1:0]  res_cell_col_d, res_pas_col_d;
  logic [ROW_W-1:0]  res_cell_row_d, res_pas_row_d;
  logic [KIND_W-1:0] res_kind_d;

  always_comb begin
    res_cell_col_d = '0;
    res_cell_row_d = '0;
    res_pas_col_d  = '0;
    res_pas_row_d  = '0;
    res_kind_d     = KIND_WALL;
    case (cmd_i.out_event)
      EV_CARVED: begin
        res_cell_col_d = COL_W'(tgt_col);
        res_cell_row_d = ROW_W'(tgt_row);
        res_pas_col_d  = COL_W'(pas_col);
        res_pas_row_d  = ROW_W'(pas_row);
      end
      EV_BACKTRACKED, EV_FINISHED: begin
        res_cell_col_d = COL_W'(top_col);
        res_cell_row_d = ROW_W'(top_row);
      end
      EV_RESTARTED: begin
        res_cell_col_d = COL_W'(1);
        res_cell_row_d = ROW_W'(1);
      end
      EV_CELL_READ: begin
        res_cell_col_d = rd_col_q;
        res_cell_row_d = rd_row_q;
        res_kind_d     = user_in_range ? grid_rdata_q : KIND_WALL;
      end
      default: res_kind_d = KIND_WALL;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      event_res_o   <= cmd_i.out_event;
      cell_col_o    <= res_cell_col_d;
      cell_row_o    <= res_cell_row_d;
      passage_col_o <= res_pas_col_d;
      passage_row_o <= res_pas_row_d;
      cell_kind_o   <= res_kind_d;
      stack_level_o <= LVL_W'(sp_q);
    end
  end

endmodule

// ===== sv/mbg_ctrl.sv =====
// Controller state machine: sequences grid sweep, moves, stack and result hand-off.
// Depends on mbg_pkg; drives mbg_datapath through mbg_cmd_t.
module mbg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mbg_pkg::mbg_status_t status_i,
  output mbg_pkg::mbg_cmd_t    cmd_o
);
  import mbg_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_TRY,
    ST_TEST,
    ST_CARVE,
    ST_FIN_START,
    ST_FIN_EXIT,
    ST_INIT,
    ST_OUT
  } state_e;

  state_e     state_q;
  logic       out_valid_q;
  logic       restart_q;
  mbg_event_e ev_q;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  // Commands for the current state
  always_comb begin
    cmd_o           = '0;
    cmd_o.grid_op   = GOP_NONE;
    cmd_o.stk_op    = STK_NONE;
    cmd_o.out_event = ev_q;
    case (state_q)
      ST_CLEAR: cmd_o.grid_op = GOP_CLEAR;
      ST_IDLE:  cmd_o.load_item = in_valid_i;
      ST_DECODE: begin
        if (status_i.mode == MODE_STEP && !status_i.sp_zero) begin
          cmd_o.stk_op    = STK_READ;
          cmd_o.try_clear = 1'b1;
        end else if (status_i.mode == MODE_READ) begin
          cmd_o.grid_op = GOP_RD_USER;
        end
      end
      ST_TRY: begin
        if (status_i.in_bounds) begin
          cmd_o.grid_op = GOP_RD_TARGET;
        end else if (status_i.try_last) begin
          cmd_o.stk_op = STK_POP;
        end else begin
          cmd_o.try_next = 1'b1;
        end
      end
      ST_TEST: begin
        if (status_i.target_wall) begin
          cmd_o.grid_op = GOP_WR_PASS;
        end else if (status_i.try_last) begin
          cmd_o.stk_op = STK_POP;
        end else begin
          cmd_o.try_next = 1'b1;
        end
      end
      ST_CARVE: begin
        cmd_o.grid_op = GOP_WR_TARGET;
        cmd_o.stk_op  = STK_PUSH;
      end
      ST_FIN_START: cmd_o.grid_op = GOP_WR_START;
      ST_FIN_EXIT:  cmd_o.grid_op = GOP_WR_EXIT;
      ST_INIT: begin
        cmd_o.grid_op = GOP_WR_START;
        cmd_o.stk_op  = STK_INIT;
      end
      ST_OUT:  cmd_o.out_load = slot_free;
      default: cmd_o.out_load = 1'b0;
    endcase
  end

  // State, result valid and pending event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      restart_q   <= 1'b0;
      ev_q        <= EV_IGNORED;
    end else begin
      // result valid: set as a result is loaded, dropped once taken
      if (state_q == ST_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_done) begin
            state_q <= restart_q ? ST_INIT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_DECODE;
        end
        ST_DECODE: begin
          case (status_i.mode)
            MODE_RESTART: begin
              restart_q <= 1'b1;
              state_q   <= ST_CLEAR;
            end
            MODE_STEP: begin
              if (status_i.sp_zero) begin
                ev_q    <= EV_IGNORED;
                state_q <= ST_OUT;
              end else begin
                state_q <= ST_TRY;
              end
            end
            MODE_READ: begin
              ev_q    <= EV_CELL_READ;
              state_q <= ST_OUT;
            end
            default: begin
              ev_q    <= EV_IGNORED;
              state_q <= ST_OUT;
            end
          endcase
        end
        ST_TRY: begin
          if (status_i.in_bounds) begin
            state_q <= ST_TEST;
          end else if (status_i.try_last) begin
            ev_q    <= status_i.sp_one ? EV_FINISHED : EV_BACKTRACKED;
            state_q <= status_i.sp_one ? ST_FIN_START : ST_OUT;
          end
        end
        ST_TEST: begin
          if (status_i.target_wall) begin
            state_q <= ST_CARVE;
          end else if (status_i.try_last) begin
            ev_q    <= status_i.sp_one ? EV_FINISHED : EV_BACKTRACKED;
            state_q <= status_i.sp_one ? ST_FIN_START : ST_OUT;
          end else begin
            state_q <= ST_TRY;
          end
        end
        ST_CARVE: begin
          ev_q    <= EV_CARVED;
          state_q <= ST_OUT;
        end
        ST_FIN_START: state_q <= ST_FIN_EXIT;
        ST_FIN_EXIT:  state_q <= ST_OUT;
        ST_INIT: begin
          restart_q <= 1'b0;
          ev_q      <= EV_RESTARTED;
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (slot_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
